// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    localparam int          NumW      = 16;
    localparam int          ValW      = 14;
    localparam int          RemW      = 10;
    localparam int          DigitW    = 4;
    localparam int          NumDigits = 4;
    localparam int          PtrW      = 2;
    localparam int          SegW      = 9;
    localparam int          OutDataW  = 16;

    localparam logic [ValW-1:0]      NUM_LIMIT   = 14'd9999;
    localparam logic [NumDigits-1:0] SEL_ALL_OFF = 4'hF;
    localparam logic [7:0]           PINS_DIRECT = 8'hF8;

    // queue entry: request kind, thousands digit, value below 1000
    typedef struct packed {
        logic              req_type;
        logic [DigitW-1:0] thou;
        logic [RemW-1:0]   rem;
    } t_item;

    // decimal digit of v at weight step (v below 10*step); parallel compares
    function automatic logic [DigitW-1:0] digit_at(input logic [ValW-1:0] v,
                                                   input logic [ValW-1:0] step);
        logic [DigitW-1:0] d;
        d = '0;
        for (int k = 1; k < 10; k++) begin
            if (v >= ValW'(k) * step) begin
                d = DigitW'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [7:0] seg_code(input logic [DigitW-1:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h3F;
            4'd1:    c = 8'h06;
            4'd2:    c = 8'h5B;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h7D;
            4'd7:    c = 8'h07;
            4'd8:    c = 8'h7F;
            4'd9:    c = 8'h6F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // A,B -> pins 0,1; C -> pin 8; D..DP -> pins 3..7
    function automatic logic [SegW-1:0] map_pins(input logic [7:0] pat);
        logic [SegW-1:0] pins;
        pins = {pat[2], (pat & PINS_DIRECT) | {6'b0, pat[1:0]}};
        pins[2] = 1'b0;
        return pins;
    endfunction

endpackage

// ===== hw/rtl/ssd_front.sv =====
module ssd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [ssd_pkg::NumW-1:0]       i_number,
    output logic                           o_push,
    input  logic                           i_full,
    output ssd_pkg::t_item                 o_item
);

    logic                          r_v;
    ssd_pkg::t_item                r_item;
    ssd_pkg::t_item                n_item;
    logic [ssd_pkg::ValW-1:0]      sat;
    logic [ssd_pkg::DigitW-1:0]    thou;
    logic [ssd_pkg::ValW-1:0]      rem_full;

    always_comb begin
        if (i_number > ssd_pkg::NumW'(ssd_pkg::NUM_LIMIT)) begin
            sat = ssd_pkg::NUM_LIMIT;
        end else begin
            sat = i_number[ssd_pkg::ValW-1:0];
        end
        thou     = ssd_pkg::digit_at(sat, 14'd1000);
        rem_full = sat - ssd_pkg::ValW'(thou) * 14'd1000;
        n_item.req_type = i_req_type;
        n_item.thou     = thou;
        n_item.rem      = rem_full[ssd_pkg::RemW-1:0];
    end

    assign o_push  = r_v && !i_full;
    assign o_ready = !r_v || !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hw/rtl/ssd_queue.sv =====
module ssd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssd_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output ssd_pkg::t_item o_item,
    input  logic           i_pop
);

    ssd_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/ssd_back.sv =====
module ssd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  ssd_pkg::t_item                    i_q_item,
    output logic                              o_pop,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_enable,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ssd_pkg::OutDataW-1:0]      o_data
);

    logic [ssd_pkg::DigitW-1:0]    r_digits [ssd_pkg::NumDigits];
    logic [ssd_pkg::PtrW-1:0]      r_ptr;
    logic [ssd_pkg::SegW-1:0]      r_seg;
    logic [ssd_pkg::NumDigits-1:0] r_sel;
    logic                          r_en;
    logic                          r_out_v;
    logic [ssd_pkg::OutDataW-1:0]  r_out;

    logic [ssd_pkg::SegW-1:0]      n_seg;
    logic [ssd_pkg::NumDigits-1:0] n_sel;
    logic [ssd_pkg::PtrW-1:0]      n_ptr;
    logic [ssd_pkg::DigitW-1:0]    hund;
    logic [ssd_pkg::DigitW-1:0]    tens;
    logic [ssd_pkg::ValW-1:0]      r2;
    logic [ssd_pkg::ValW-1:0]      r1;
    logic                          is_tick;

    assign o_pop   = i_q_valid && (!r_out_v || i_ready);
    assign is_tick = (i_q_item.req_type == ssd_pkg::REQ_TICK);

    always_comb begin
        hund = ssd_pkg::digit_at(ssd_pkg::ValW'(i_q_item.rem), 14'd100);
        r2   = ssd_pkg::ValW'(i_q_item.rem) - ssd_pkg::ValW'(hund) * 14'd100;
        tens = ssd_pkg::digit_at(r2, 14'd10);
        r1   = r2 - ssd_pkg::ValW'(tens) * 14'd10;
    end

    always_comb begin
        n_seg = r_seg;
        n_sel = r_sel;
        n_ptr = r_ptr;
        if (is_tick && r_en) begin
            n_seg = ssd_pkg::map_pins(ssd_pkg::seg_code(r_digits[r_ptr]));
            n_sel = ssd_pkg::SEL_ALL_OFF
                    & ~(ssd_pkg::NumDigits'(1) << r_ptr);
            n_ptr = r_ptr + ssd_pkg::PtrW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::NumDigits; i++) begin
                r_digits[i] <= '0;
            end
            r_ptr   <= '0;
            r_seg   <= '0;
            r_sel   <= ssd_pkg::SEL_ALL_OFF;
            r_en    <= 1'b1;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_en <= i_cfg_enable;
                if (!i_cfg_enable) begin
                    r_seg <= '0;
                    r_sel <= ssd_pkg::SEL_ALL_OFF;
                end
            end
            if (o_pop) begin
                r_out_v <= 1'b1;
                if (!is_tick) begin
                    r_digits[0] <= i_q_item.thou;
                    r_digits[1] <= hund;
                    r_digits[2] <= tens;
                    r_digits[3] <= r1[ssd_pkg::DigitW-1:0];
                end else begin
                    r_seg <= n_seg;
                    r_sel <= n_sel;
                    r_ptr <= n_ptr;
                end
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= {3'b000, n_sel, n_seg};
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/seven_segment_scan_driver_unit.sv =====
// Path: a request is registered in the front stage, written into the queue,
// then loaded into the output register; a full queue or a stalled output can hold it.
// Throughput: one request per cycle sustained while the output is accepted; front and
// output registers hold one request each and the queue two, so either side stalls alone.
// Reset (i_rst_n low, synchronous): display enabled, digits zero, scan
// pointer zero, all segments off and all digit selects high; no request held.
module seven_segment_scan_driver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] number
    input  logic [0:0]  i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [8:0] segment_pins, [12:9] digit_select_n
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data        // [0] display_enable
);

    logic           push;
    logic           full;
    logic           q_valid;
    logic           pop;
    ssd_pkg::t_item f_item;
    ssd_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    ssd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req_type (i_s_axis_tuser[0]),
        .i_number   (i_s_axis_tdata),
        .o_push     (push),
        .i_full     (full),
        .o_item     (f_item)
    );

    ssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    ssd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_enable (i_cfg_data[0]),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata)
    );

endmodule

// ===== hw/rtl/ssd_checker.sv =====
module ssd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // padding and pin 2 never driven
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:13] == 3'b000 && !o_m_axis_tdata[2]))
        else $error("padding or pin 2 set");

    // at most one digit selected
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($countones(o_m_axis_tdata[12:9]) == 3 || o_m_axis_tdata[12:9] == 4'hF))
        else $error("more than one digit selected");

    // blank selects go with blank segments, and a lit digit always shows something
    a_blank_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[12:9] == 4'hF) == (o_m_axis_tdata[8:0] == 9'd0)))
        else $error("segment and select latches disagree");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
